// ===== rtl/core/htd_pkg.sv =====
// Shared types and constants for the Huffman tree decoder.
`timescale 1ns / 1ps

package htd_pkg;

  localparam int NODE_W     = 8;
  localparam int CHILD_W    = 9;
  localparam int COUNT_W    = 24;
  localparam int SYMBOL_W   = 8;
  localparam int TREE_NODES = 256;

  // Walk restarts here after every symbol
  localparam logic [NODE_W-1:0] ROOT_NODE = 8'd254;

  // Input item kinds
  localparam logic REQ_NODE_WRITE = 1'b0;
  localparam logic REQ_DATA_BYTE  = 1'b1;

  // One tree node: child taken on a 1 bit in the upper half
  typedef struct packed {
    logic [CHILD_W-1:0] child_one;
    logic [CHILD_W-1:0] child_zero;
  } node_t;

  // Write beat into the tree table
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    node_t             data;
  } tree_wr_t;

endpackage

// ===== rtl/core/htd_tree_mem.sv =====
// Tree node table: one write port, one registered read port.
`timescale 1ns / 1ps

module htd_tree_mem (
  input  logic                          clk,
  input  htd_pkg::tree_wr_t             wr,
  input  logic [htd_pkg::NODE_W-1:0]    rd_addr,
  output htd_pkg::node_t                rd_data
);
  import htd_pkg::*;

  node_t mem [TREE_NODES];

  // Store node writes
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read every cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/htd_walker.sv =====
// Bit-serial tree walker: sequencer, symbol count, pending symbol and output register.
`timescale 1ns / 1ps

module htd_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [7:0]                    node_index,
  input  logic [htd_pkg::CHILD_W-1:0]   child_zero,
  input  logic [htd_pkg::CHILD_W-1:0]   child_one,
  input  logic [7:0]                    data_byte,
  input  logic [htd_pkg::COUNT_W-1:0]   expanded_length,
  output htd_pkg::tree_wr_t             tree_wr,
  output logic [htd_pkg::NODE_W-1:0]    rd_addr,
  input  htd_pkg::node_t                rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [htd_pkg::SYMBOL_W-1:0]  symbol,
  output logic                          last_of_item,
  output logic                          chunk_done
);
  import htd_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BIT   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]          state, state_next;
  logic [2:0]          bit_idx, bit_idx_next;
  logic [7:0]          data_reg;
  logic [NODE_W-1:0]   current_node, current_node_next;
  logic [COUNT_W-1:0]  bytes_emitted, bytes_emitted_next;
  logic                pend_valid, pend_valid_next;
  logic [SYMBOL_W-1:0] pend_symbol;
  logic                pend_done;
  logic                pend_load;
  logic                out_load, out_last;

  logic                in_take;
  logic                out_free;
  logic [CHILD_W-1:0]  child;
  logic                is_leaf;
  logic [COUNT_W-1:0]  count_inc;
  logic                hit_len;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Node write beats go straight to the table
  assign tree_wr.en   = in_take && (req_type == REQ_NODE_WRITE);
  assign tree_wr.addr = node_index;
  assign tree_wr.data = '{child_one: child_one, child_zero: child_zero};

  // Select child for the current bit
  assign child     = data_reg[bit_idx] ? rd_data.child_one : rd_data.child_zero;
  assign is_leaf   = !child[CHILD_W-1];
  assign count_inc = bytes_emitted + COUNT_W'(1);
  assign hit_len   = (count_inc >= expanded_length);

  // Read the node the walk stands on next cycle
  assign rd_addr = current_node_next;

  // Sequencer
  always_comb begin
    state_next         = state;
    bit_idx_next       = bit_idx;
    current_node_next  = current_node;
    bytes_emitted_next = bytes_emitted;
    pend_valid_next    = pend_valid;
    pend_load          = 1'b0;
    out_load           = 1'b0;
    out_last           = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_take && (req_type == REQ_DATA_BYTE)) begin
          state_next   = S_BIT;
          bit_idx_next = 3'd0;
        end
      end
      S_BIT: begin
        if (!is_leaf) begin
          // Descend one level
          current_node_next = child[NODE_W-1:0];
          if (bit_idx == 3'd7) begin
            state_next = S_FLUSH;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
          end
        end else if (!pend_valid || out_free) begin
          // Symbol found: push older pending symbol, hold the new one
          out_load           = pend_valid;
          pend_load          = 1'b1;
          pend_valid_next    = 1'b1;
          current_node_next  = ROOT_NODE;
          bytes_emitted_next = hit_len ? '0 : count_inc;
          if (hit_len || (bit_idx == 3'd7)) begin
            state_next = S_FLUSH;
          end else begin
            bit_idx_next = bit_idx + 3'd1;
          end
        end
      end
      S_FLUSH: begin
        // Release the last symbol of the byte
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      bit_idx       <= 3'd0;
      current_node  <= ROOT_NODE;
      bytes_emitted <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      bit_idx       <= bit_idx_next;
      current_node  <= current_node_next;
      bytes_emitted <= bytes_emitted_next;
      pend_valid    <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      data_reg <= data_byte;
    end
    if (pend_load) begin
      pend_symbol <= child[SYMBOL_W-1:0];
      pend_done   <= hit_len;
    end
    if (out_load) begin
      symbol       <= pend_symbol;
      chunk_done   <= pend_done;
      last_of_item <= out_last;
    end
  end

endmodule

// ===== rtl/core/huffman_tree_decoder.sv =====
// Top level of the Huffman tree decoder: length register and unit wiring.
`timescale 1ns / 1ps

// Decodes an LSB-first Huffman stream against a 256-node tree table loaded
// by node write beats. A compressed byte holds the input off while the walker
// steps through its bits and then a closing flush step; the next beat waits
// longer while the output stalls and less when a chunk ends inside the byte.
// The bit steps are set by the single tree-table read port, which supplies
// one node per bit step. Each symbol is held in a pending register so that
// the last symbol of a byte can be flagged; a byte with no symbol produces no
// beat. The user must write expanded_length only while the decoder is idle;
// the block itself does not enforce this.
module huffman_tree_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [htd_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [7:0]                    node_index,
  input  logic [htd_pkg::CHILD_W-1:0]   child_zero,
  input  logic [htd_pkg::CHILD_W-1:0]   child_one,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [htd_pkg::SYMBOL_W-1:0]  symbol,
  output logic                          last_of_item,
  output logic                          chunk_done
);
  import htd_pkg::*;

  logic [COUNT_W-1:0] expanded_length;
  tree_wr_t           tree_wr;
  logic [NODE_W-1:0]  rd_addr;
  node_t              rd_data;

  assign cfg_ready = 1'b1;

  // Chunk length register
  always_ff @(posedge clk) begin
    if (rst) begin
      expanded_length <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      expanded_length <= cfg_data;
    end
  end

  htd_tree_mem u_mem (
    .clk     (clk),
    .wr      (tree_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  htd_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .node_index      (node_index),
    .child_zero      (child_zero),
    .child_one       (child_one),
    .data_byte       (data_byte),
    .expanded_length (expanded_length),
    .tree_wr         (tree_wr),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .symbol          (symbol),
    .last_of_item    (last_of_item),
    .chunk_done      (chunk_done)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the Huffman tree decoder: directed table, then random beats.
`timescale 1ns / 1ps

module tb_top;
  import htd_pkg::*;

  localparam int RANDOM_PER_PHASE = 70;
  localparam int SETTLE_CYCLES    = 16;
  localparam int MAX_REPORTS      = 10;
  localparam int NUM_DIRECTED     = 22;

  // One decoded symbol beat as seen on the output
  typedef struct packed {
    logic [SYMBOL_W-1:0] sym;
    logic                last;
    logic                done;
  } decoded_t;

  typedef enum logic [1:0] {ROW_NODE, ROW_BYTE, ROW_LEN} row_kind_t;

  // Directed stimulus row; value is the data byte or the chunk length
  typedef struct {
    row_kind_t          kind;
    logic [NODE_W-1:0]  idx;
    logic [CHILD_W-1:0] c0;
    logic [CHILD_W-1:0] c1;
    logic [COUNT_W-1:0] value;
    logic               typed;
    decoded_t           want;
  } stim_row_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_valid  = 1'b0;
  logic [COUNT_W-1:0]   cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 req_type   = 1'b0;
  logic [7:0]           node_index = '0;
  logic [CHILD_W-1:0]   child_zero = '0;
  logic [CHILD_W-1:0]   child_one  = '0;
  logic [7:0]           data_byte  = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_ready;
  logic                 in_stall;
  logic                 out_valid;
  logic [SYMBOL_W-1:0]  symbol;
  logic                 last_of_item;
  logic                 chunk_done;

  // Shadow of the decoder state
  node_t              tree_mem [TREE_NODES];
  bit                 node_known [TREE_NODES];
  logic [NODE_W-1:0]  written_nodes [$];
  logic [NODE_W-1:0]  walk_node;
  logic [COUNT_W-1:0] emitted;
  logic [COUNT_W-1:0] chunk_len;
  decoded_t           symbols_due [$];

  int mismatches    = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 82;

  huffman_tree_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .node_index   (node_index),
    .child_zero   (child_zero),
    .child_one    (child_one),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .symbol       (symbol),
    .last_of_item (last_of_item),
    .chunk_done   (chunk_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Record a node write in the shadow table
  task automatic store_node(input logic [NODE_W-1:0] idx, input logic [CHILD_W-1:0] c0,
                            input logic [CHILD_W-1:0] c1);
    tree_mem[idx] = '{child_one: c1, child_zero: c0};
    if (!node_known[idx]) begin
      node_known[idx] = 1'b1;
      written_nodes.push_back(idx);
    end
  endtask

  // Walk one compressed byte and queue the symbols it yields
  task automatic decode_byte(input logic [7:0] data, input logic typed, input decoded_t want);
    decoded_t           hold [8];
    logic [CHILD_W-1:0] child;
    int                 n;
    n = 0;
    for (int b = 0; b < 8; b++) begin
      child = data[b] ? tree_mem[walk_node].child_one : tree_mem[walk_node].child_zero;
      if (child < CHILD_W'(TREE_NODES)) begin
        emitted = emitted + 1'b1;
        hold[n] = '{sym: child[SYMBOL_W-1:0], last: 1'b0, done: (emitted >= chunk_len)};
        walk_node = ROOT_NODE;
        n++;
        // Drop the rest of the byte once the chunk is full
        if (hold[n-1].done) begin
          emitted = '0;
          break;
        end
      end else begin
        walk_node = child[NODE_W-1:0];
      end
    end
    if (typed) begin
      symbols_due.push_back(want);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (i == n - 1) hold[i].last = 1'b1;
        symbols_due.push_back(hold[i]);
      end
    end
  endtask

  // Leaf symbol or pointer to a node already in the table
  function automatic logic [CHILD_W-1:0] pick_child();
    if ($urandom_range(99) < 55 || written_nodes.size() == 0)
      return CHILD_W'($urandom_range(255));
    return CHILD_W'(TREE_NODES) + written_nodes[$urandom_range(written_nodes.size() - 1)];
  endfunction

  // Present one input beat, hold it until taken, then update the shadow
  task automatic send_item(input logic req, input logic [7:0] idx,
                           input logic [CHILD_W-1:0] c0, input logic [CHILD_W-1:0] c1,
                           input logic [7:0] data, input logic typed, input decoded_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    node_index <= idx;
    child_zero <= c0;
    child_one  <= c1;
    data_byte  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req == REQ_NODE_WRITE) store_node(idx, c0, c1);
    else decode_byte(data, typed, want);
  endtask

  // Drain all pending symbols and let any symbol-less walk finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (symbols_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [COUNT_W-1:0] len);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    chunk_len = len;
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted output beat with the oldest pending symbol
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{sym: symbol, last: last_of_item, done: chunk_done};
      if (symbols_due.size() == 0) begin
        note_error($sformatf("unexpected beat sym=%02h last=%0b done=%0b",
                             symbol, last_of_item, chunk_done));
      end else begin
        want = symbols_due.pop_front();
        if (got !== want)
          note_error($sformatf("sym exp %02h got %02h, last exp %0b got %0b, done exp %0b got %0b",
                               want.sym, got.sym, want.last, got.last, want.done, got.done));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t          dir_rows [NUM_DIRECTED];
    logic [NODE_W-1:0]  idx;
    logic [COUNT_W-1:0] phase_len;

    // Root first; later rows build a three-level tree around it
    dir_rows = '{
      '{ROW_NODE, 8'd254, 9'h000, 9'h0FF, 24'h0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h00,     1'b1, '{8'h00, 1'b1, 1'b1}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'hFF,     1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'hA5,     1'b1, '{8'hFF, 1'b1, 1'b1}},
      '{ROW_LEN,  8'd0,   9'h000, 9'h000, 24'hFFFFFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h5A,     1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_NODE, 8'd253, 9'h1FE, 9'h0FE, 24'h0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_NODE, 8'd255, 9'h080, 9'h1FD, 24'h0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_NODE, 8'd254, 9'h1FF, 9'h001, 24'h0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h00,     1'b0, '{8'h00, 1'b0, 1'b0}},
      // bits end inside a code: no symbol, walk carries into the next byte
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h92,     1'b0, '{8'h00, 1'b0, 1'b0}},
      // rewrite the node the walk is parked on
      '{ROW_NODE, 8'd253, 9'h1FE, 9'h07E, 24'h0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h01,     1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_NODE, 8'd0,   9'h1FF, 9'h000, 24'h0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      // drop the length below the running count
      '{ROW_LEN,  8'd0,   9'h000, 9'h000, 24'd2,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'hFF,     1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'hFF,     1'b0, '{8'h00, 1'b0, 1'b0}},
      // zero length behaves as one
      '{ROW_LEN,  8'd0,   9'h000, 9'h000, 24'd0,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'hFF,     1'b1, '{8'h01, 1'b1, 1'b1}},
      '{ROW_LEN,  8'd0,   9'h000, 9'h000, 24'd3,      1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h7F,     1'b0, '{8'h00, 1'b0, 1'b0}},
      '{ROW_BYTE, 8'd0,   9'h000, 9'h000, 24'h00,     1'b0, '{8'h00, 1'b0, 1'b0}}
    };

    walk_node = ROOT_NODE;
    emitted   = '0;
    chunk_len = COUNT_W'(1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_NODE: send_item(REQ_NODE_WRITE, dir_rows[i].idx, dir_rows[i].c0, dir_rows[i].c1,
                            8'($urandom), 1'b0, '0);
        ROW_BYTE: send_item(REQ_DATA_BYTE, 8'($urandom), CHILD_W'($urandom),
                            CHILD_W'($urandom), dir_rows[i].value[7:0], dir_rows[i].typed,
                            dir_rows[i].want);
        default:  set_length(dir_rows[i].value);
      endcase
    end

    // Random phases: receiver-heavy gaps, sender-heavy gaps, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       phase_len = COUNT_W'(5);
        1:       phase_len = COUNT_W'(1);
        default: phase_len = COUNT_W'($urandom_range(40, 2));
      endcase
      set_length(phase_len);
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 82 : 0;
      recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 31 : 0;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Hold off input once until the output has fully drained
        if (ph == 0 && k == RANDOM_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (symbols_due.size() != 0);
        end
        // Mostly rework nodes near the root so walks get deep
        idx = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(255, 246));
        if ($urandom_range(99) < 18)
          send_item(REQ_NODE_WRITE, idx, pick_child(), pick_child(), 8'($urandom), 1'b0, '0);
        else
          send_item(REQ_DATA_BYTE, 8'($urandom), CHILD_W'($urandom), CHILD_W'($urandom),
                    8'($urandom), 1'b0, '0);
      end
    end

    // Drain, then watch for stray beats
    in_valid <= 1'b0;
    do @(posedge clk); while (symbols_due.size() != 0);
    repeat (40) @(posedge clk);
    if (symbols_due.size() != 0) note_error("symbols still pending at end of run");

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
